@@ hw/rtl/iee_pkg.sv @@
// Shared types and constants for the infix expression evaluator.
// Operator codes, status codes and character codes. No dependencies.
package iee_pkg;
	localparam logic [2:0] OPC_ADD  = 3'd0;
	localparam logic [2:0] OPC_SUB  = 3'd1;
	localparam logic [2:0] OPC_MUL  = 3'd2;
	localparam logic [2:0] OPC_DIV  = 3'd3;
	localparam logic [2:0] OPC_LPAR = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DIVZERO   = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	localparam logic [7:0] CH_ADD  = 8'h2B;
	localparam logic [7:0] CH_SUB  = 8'h2D;
	localparam logic [7:0] CH_MUL  = 8'h2A;
	localparam logic [7:0] CH_DIV  = 8'h2F;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_E    = 8'h65;

	localparam logic [2:0] CFG_VAR_A = 3'd0;
	localparam logic [2:0] CFG_VAR_B = 3'd1;
	localparam logic [2:0] CFG_VAR_C = 3'd2;
	localparam logic [2:0] CFG_VAR_D = 3'd3;
	localparam logic [2:0] CFG_VAR_E = 3'd4;

	typedef struct packed {
		logic       start;
		logic [2:0] op;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic        divzero;
		logic [31:0] value;
	} alu_rsp_t;
endpackage

@@ hw/rtl/iee_ram.sv @@
// Generic RAM with one write port and one registered read port.
// No dependencies.
module iee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hw/rtl/iee_alu.sv @@
// Shared Q-format arithmetic unit: add/sub, multiply, and a restoring divide
// that yields one quotient bit per cycle. Uses iee_pkg.
module iee_alu import iee_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  alu_req_t    req,
	input  logic [31:0] opa,
	input  logic [31:0] opb,
	output alu_rsp_t    rsp
);
	localparam int DW = 32 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);
	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_MUL  = 2'd1;
	localparam logic [1:0] A_DIV  = 2'd2;
	localparam logic [1:0] A_FIN  = 2'd3;

	logic [1:0]    state_q;
	logic [63:0]   prod_q;
	logic [DW-1:0] num_q;
	logic [DW-1:0] quo_q;
	logic [32:0]   rem_q;
	logic [31:0]   den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   res_q;
	logic          done_q;
	logic          dz_q;

	logic signed [32:0] sum;
	logic signed [63:0] shp;
	logic [32:0]        trial;
	logic [DW:0]        qs;
	logic [31:0]        maga;
	logic [31:0]        magb;

	function automatic logic [31:0] sat_fn(input logic signed [DW:0] v);
		if (v > $signed({{(DW-31){1'b0}}, 32'h7FFFFFFF}))
			return 32'h7FFFFFFF;
		if (v < $signed({{(DW-31){1'b1}}, 32'h80000000}))
			return 32'h80000000;
		return v[31:0];
	endfunction

	always_comb begin
		if (req.op == OPC_ADD)
			sum = $signed({opa[31], opa}) + $signed({opb[31], opb});
		else
			sum = $signed({opa[31], opa}) - $signed({opb[31], opb});
		shp   = $signed(prod_q) >>> FRAC_BITS;
		trial = {rem_q[31:0], num_q[DW-1]} - {1'b0, den_q};
		qs    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		maga  = opa[31] ? (~opa + 32'd1) : opa;
		magb  = opb[31] ? (~opb + 32'd1) : opb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			dz_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						dz_q <= 1'b0;
						case (req.op)
							OPC_ADD, OPC_SUB: begin
								if (sum > 33'sh07FFFFFFF)       res_q <= 32'h7FFFFFFF;
								else if (sum < -33'sh080000000) res_q <= 32'h80000000;
								else                           res_q <= sum[31:0];
								done_q <= 1'b1;
							end
							OPC_MUL: begin
								prod_q  <= $signed(opa) * $signed(opb);
								state_q <= A_MUL;
							end
							default: begin
								if (opb == '0) begin
									dz_q   <= 1'b1;
									done_q <= 1'b1;
								end else begin
									num_q <= DW'(maga) << FRAC_BITS;
									den_q <= magb;
									neg_q <= opa[31] ^ opb[31];
									rem_q <= '0;
									quo_q <= '0;
									cnt_q <= CW'(DW);
									state_q <= A_DIV;
								end
							end
						endcase
					end
				end
				A_MUL: begin
					if (shp > 64'sh7FFFFFFF)        res_q <= 32'h7FFFFFFF;
					else if (shp < -64'sh80000000)  res_q <= 32'h80000000;
					else                            res_q <= shp[31:0];
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				A_DIV: begin
					num_q <= num_q << 1;
					if (!trial[32]) begin
						rem_q <= trial;
						quo_q <= {quo_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[31:0], num_q[DW-1]};
						quo_q <= {quo_q[DW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) state_q <= A_FIN;
				end
				default: begin
					res_q   <= sat_fn(qs);
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp = '{done: done_q, divzero: dz_q, value: res_q};
endmodule

@@ hw/rtl/infix_expression_evaluator_core.sv @@
// Top level of the infix expression evaluator: sequencer, stacks, registers.
// Uses iee_pkg, iee_ram (value and operator stacks) and iee_alu.
//
// Usage: characters arrive on the input channel (char_code, end_of_expr,
// in_valid/in_ready). Letters a..e push the configured Q16.16 values;
// + - * / ( ) drive the two-stack reduction; other codes are ignored.
// The character marked end_of_expr produces one request on the output
// channel (result_value, status, out_valid/out_ready); stacks then clear.
// The user must write variables on the cfg channel (cfg_index, cfg_data)
// only while idle; the block itself does not enforce this. Each character
// passes the dispatch and finish states; an operator also runs its
// reductions, each reading both operands through the registered stack
// read ports and waiting on the shared arithmetic unit. An end-marked
// character adds final reductions and the result states before its request.
// in_ready is low while a character is being processed. A finished result
// sits in the output register; the next character is taken meanwhile,
// but a second end-marked character waits until the result is taken.
// Reset clears counts, error and variables; stack contents need no clear.
module infix_expression_evaluator_core import iee_pkg::*; #(
	parameter int VALUE_DEPTH = 16,
	parameter int OP_DEPTH    = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        end_of_expr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_value,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int VAW = $clog2(VALUE_DEPTH);
	localparam int OAW = $clog2(OP_DEPTH);
	localparam int VCW = $clog2(VALUE_DEPTH + 1);
	localparam int OCW = $clog2(OP_DEPTH + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_LOOP  = 4'd2;
	localparam logic [3:0] S_RDB   = 4'd3;
	localparam logic [3:0] S_RDA   = 4'd4;
	localparam logic [3:0] S_ALU   = 4'd5;
	localparam logic [3:0] S_WAIT  = 4'd6;
	localparam logic [3:0] S_PUSH  = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_RES   = 4'd9;
	localparam logic [3:0] S_RES2  = 4'd10;
	localparam logic [3:0] S_OUTW  = 4'd11;

	logic [3:0]     state_q;
	logic [31:0]    var_q [5];
	logic [VCW-1:0] vcnt_q;
	logic [OCW-1:0] ocnt_q;
	logic [1:0]     err_q;
	logic [7:0]     ch_q;
	logic           last_q;
	logic [2:0]     newop_q;
	logic           mode_q;  // 0: operator, 1: right paren
	logic           end_q;   // final reduction of the expression
	logic [31:0]    b_q;
	logic [31:0]    a_q;
	logic [2:0]     top_q;
	logic           out_valid_q;
	logic [31:0]    res_q;
	logic [1:0]     st_q;

	logic           v_we;
	logic [VAW-1:0] v_waddr;
	logic [31:0]    v_wdata;
	logic [VAW-1:0] v_raddr;
	logic [31:0]    v_rdata;
	logic           o_we;
	logic [OAW-1:0] o_waddr;
	logic [2:0]     o_wdata;
	logic [OAW-1:0] o_raddr;
	logic [2:0]     o_rdata;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic       is_op;
	logic [2:0] op_code;

	iee_ram #(.WIDTH(32), .DEPTH(VALUE_DEPTH)) u_vstack (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata)
	);

	iee_ram #(.WIDTH(3), .DEPTH(OP_DEPTH)) u_ostack (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.raddr(o_raddr), .rdata(o_rdata)
	);

	iee_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
		.clk(clk), .arst_n(arst_n), .req(alu_req), .opa(a_q), .opb(b_q), .rsp(alu_rsp)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign result_value = res_q;
	assign status = st_q;

	always_comb begin
		is_op   = 1'b1;
		op_code = OPC_ADD;
		case (ch_q)
			CH_ADD:  op_code = OPC_ADD;
			CH_SUB:  op_code = OPC_SUB;
			CH_MUL:  op_code = OPC_MUL;
			CH_DIV:  op_code = OPC_DIV;
			default: is_op = 1'b0;
		endcase
	end

	// stack ports
	always_comb begin
		v_we    = 1'b0;
		v_waddr = VAW'(vcnt_q);
		v_wdata = var_q[3'(ch_q - CH_A)];
		o_we    = 1'b0;
		o_waddr = OAW'(ocnt_q);
		o_wdata = newop_q;
		o_raddr = OAW'(ocnt_q - 1'b1);
		v_raddr = VAW'(vcnt_q - 1'b1);
		alu_req = '{start: 1'b0, op: top_q};
		case (state_q)
			S_DISP: begin
				if (err_q == ST_OK && ch_q inside {[CH_A:CH_E]} &&
					vcnt_q != VCW'(VALUE_DEPTH))
					v_we = 1'b1;
				if (err_q == ST_OK && ch_q == CH_LPAR && ocnt_q != OCW'(OP_DEPTH)) begin
					o_we    = 1'b1;
					o_wdata = OPC_LPAR;
				end
			end
			S_RDB: v_raddr = VAW'(vcnt_q - 2'd2);
			S_ALU: alu_req.start = 1'b1;
			S_WAIT: begin
				// next top of the op stack once the current one is popped
				o_raddr = OAW'(ocnt_q - 2'd2);
				if (alu_rsp.done && !alu_rsp.divzero) begin
					v_we    = 1'b1;
					v_waddr = VAW'(vcnt_q - 2'd2);
					v_wdata = alu_rsp.value;
				end
			end
			S_PUSH: o_we = (ocnt_q != OCW'(OP_DEPTH));
			S_RES:  v_raddr = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcnt_q      <= '0;
			ocnt_q      <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 5; i++) var_q[i] <= '0;
		end else begin
			if (cfg_valid && cfg_index <= CFG_VAR_E)
				var_q[cfg_index - CFG_VAR_A] <= cfg_data;
			if (out_valid_q && out_ready && state_q != S_RES2) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ch_q    <= char_code;
						last_q  <= end_of_expr;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_FIN;
					newop_q <= op_code;
					mode_q  <= (ch_q == CH_RPAR);
					end_q   <= 1'b0;
					if (err_q == ST_OK) begin
						if (ch_q inside {[CH_A:CH_E]}) begin
							if (vcnt_q == VCW'(VALUE_DEPTH)) err_q <= ST_MALFORMED;
							else vcnt_q <= vcnt_q + 1'b1;
						end else if (ch_q == CH_LPAR) begin
							if (ocnt_q == OCW'(OP_DEPTH)) err_q <= ST_MALFORMED;
							else ocnt_q <= ocnt_q + 1'b1;
						end else if (ch_q == CH_RPAR) begin
							if (ocnt_q == '0) err_q <= ST_MALFORMED;
							else state_q <= S_LOOP;
						end else if (is_op) begin
							state_q <= (ocnt_q == '0) ? S_PUSH : S_LOOP;
						end
					end
				end
				S_LOOP: begin
					// o_rdata holds op stack top (address set last cycle)
					top_q <= o_rdata;
					if (mode_q && o_rdata == OPC_LPAR) begin
						ocnt_q  <= ocnt_q - 1'b1;
						state_q <= S_FIN;
					end else if (!mode_q && !end_q && (o_rdata == OPC_LPAR ||
						(o_rdata[2:1] == 2'b00 && newop_q[1]))) begin
						state_q <= S_PUSH;
					end else if (o_rdata == OPC_LPAR || vcnt_q < VCW'(2)) begin
						err_q   <= ST_MALFORMED;
						state_q <= S_FIN;
					end else state_q <= S_RDB;
				end
				S_RDB: begin
					b_q     <= v_rdata;
					state_q <= S_RDA;
				end
				S_RDA: begin
					a_q     <= v_rdata;
					state_q <= S_ALU;
				end
				S_ALU: state_q <= S_WAIT;
				S_WAIT: begin
					if (alu_rsp.done) begin
						if (alu_rsp.divzero) begin
							err_q   <= ST_DIVZERO;
							state_q <= S_FIN;
						end else begin
							vcnt_q <= vcnt_q - 1'b1;
							ocnt_q <= ocnt_q - 1'b1;
							if (ocnt_q != OCW'(1)) state_q <= S_LOOP;
							else if (mode_q) begin
								err_q   <= ST_MALFORMED;
								state_q <= S_FIN;
							end else if (end_q) state_q <= S_FIN;
							else state_q <= S_PUSH;
						end
					end
				end
				S_PUSH: begin
					if (ocnt_q == OCW'(OP_DEPTH)) err_q <= ST_MALFORMED;
					else ocnt_q <= ocnt_q + 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!last_q) state_q <= S_IDLE;
					else if (err_q == ST_OK && ocnt_q != '0) begin
						mode_q  <= 1'b0;
						end_q   <= 1'b1;
						newop_q <= OPC_ADD;
						state_q <= S_LOOP;
					end else state_q <= S_RES;
				end
				S_RES: state_q <= S_RES2;
				S_RES2: begin
					if (!out_valid_q || out_ready) begin
						if (err_q == ST_OK && vcnt_q != VCW'(1)) begin
							st_q  <= ST_MALFORMED;
							res_q <= '0;
						end else begin
							st_q  <= err_q;
							res_q <= (err_q == ST_OK) ? v_rdata : '0;
						end
						out_valid_q <= 1'b1;
						vcnt_q  <= '0;
						ocnt_q  <= '0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end else state_q <= S_OUTW;
				end
				default: begin
					if (out_valid_q && out_ready) state_q <= S_RES;
				end
			endcase
		end
	end
endmodule

@@ tb/sv/tb_infix_expression_evaluator_core.sv @@
// Testbench for infix_expression_evaluator_core: drives expression characters,
// predicts each end-of-expression result with its own two-stack evaluator, checks results.
// Depends on iee_pkg and the core RTL.
module tb_infix_expression_evaluator_core;
	import iee_pkg::*;

	localparam int VDEPTH = 16;
	localparam int ODEPTH = 16;
	localparam int FRAC   = 16;
	localparam int SETTLE = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_code;
	logic        end_of_expr;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] result_value;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	typedef struct {
		logic [31:0] value;
		logic [1:0]  status;
	} eval_result_t;

	// predictor state
	logic signed [31:0] var_val [5];
	logic signed [31:0] vstack [VDEPTH];
	logic [2:0]         ostack [ODEPTH];
	int                 vcnt;
	int                 ocnt;
	logic [1:0]         err;

	eval_result_t expected_results [$];
	int  mismatches;
	int  results_seen;
	int  chars_sent;
	int  expr_sent;
	bit  long_hold;
	int  hold_cycles;

	infix_expression_evaluator_core #(
		.VALUE_DEPTH(VDEPTH),
		.OP_DEPTH(ODEPTH),
		.FRAC_BITS(FRAC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.end_of_expr(end_of_expr),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_value(result_value),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("timeout: %0d results pending", expected_results.size());
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic int op_prio(input logic [2:0] op);
		if (op == OPC_ADD || op == OPC_SUB) return 0;
		if (op == OPC_MUL || op == OPC_DIV) return 1;
		return -1;
	endfunction

	function automatic void flag_error(input logic [1:0] code);
		if (err == ST_OK) err = code;
	endfunction

	function automatic bit apply_top_op();
		logic signed [63:0] a, b, r;
		logic [2:0] op;
		if (ocnt == 0 || vcnt < 2) begin
			flag_error(ST_MALFORMED);
			return 0;
		end
		op = ostack[ocnt-1];
		if (op == OPC_LPAR) begin
			flag_error(ST_MALFORMED);
			return 0;
		end
		b = vstack[vcnt-1];
		a = vstack[vcnt-2];
		case (op)
			OPC_ADD: r = a + b;
			OPC_SUB: r = a - b;
			OPC_MUL: r = (a * b) >>> FRAC;
			default: begin
				if (b == 0) begin
					flag_error(ST_DIVZERO);
					return 0;
				end
				r = (a <<< FRAC) / b;
			end
		endcase
		ocnt--;
		vcnt--;
		vstack[vcnt-1] = sat64(r);
		return 1;
	endfunction

	function automatic void consume_char(input logic [7:0] c);
		logic [2:0] op;
		if (c >= CH_A && c <= CH_E) begin
			if (vcnt >= VDEPTH) flag_error(ST_MALFORMED);
			else vstack[vcnt++] = var_val[c - CH_A];
			return;
		end
		if (c == CH_LPAR) begin
			if (ocnt >= ODEPTH) flag_error(ST_MALFORMED);
			else ostack[ocnt++] = OPC_LPAR;
			return;
		end
		if (c == CH_RPAR) begin
			forever begin
				if (ocnt == 0) begin
					flag_error(ST_MALFORMED);
					return;
				end
				if (ostack[ocnt-1] == OPC_LPAR) begin
					ocnt--;
					return;
				end
				if (!apply_top_op()) return;
			end
		end
		case (c)
			CH_ADD: op = OPC_ADD;
			CH_SUB: op = OPC_SUB;
			CH_MUL: op = OPC_MUL;
			CH_DIV: op = OPC_DIV;
			default: return;
		endcase
		while (ocnt > 0 && op_prio(ostack[ocnt-1]) >= op_prio(op))
			if (!apply_top_op()) return;
		if (ocnt >= ODEPTH) flag_error(ST_MALFORMED);
		else ostack[ocnt++] = op;
	endfunction

	function automatic void predict_char(input logic [7:0] c, input logic last);
		eval_result_t r;
		if (err == ST_OK) consume_char(c);
		if (!last) return;
		while (err == ST_OK && ocnt > 0)
			if (!apply_top_op()) break;
		if (err == ST_OK && vcnt != 1) flag_error(ST_MALFORMED);
		r.value = (err == ST_OK) ? vstack[0] : 32'd0;
		r.status = err;
		expected_results.push_back(r);
		vcnt = 0;
		ocnt = 0;
		err = ST_OK;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		eval_result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected request", result_value, 0);
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status) report_mismatch("status", status, e.status);
				if (result_value !== e.value)
					report_mismatch("result_value", result_value, e.value);
			end
		end
	end

	// receiver stall pattern, with an optional long hold-off
	initial begin
		int pat;
		out_ready = 1'b0;
		pat = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				if (hold_cycles > 0) hold_cycles--;
				else long_hold = 0;
			end else begin
				pat++;
				if ((pat / 300) % 3 == 0) out_ready <= 1'b1;
				else out_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	int burst_left;

	task automatic send_char(input logic [7:0] c, input logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 1)) repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		burst_left--;
		in_valid = 1'b1;
		char_code = c;
		end_of_expr = last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_char(c, last);
		chars_sent++;
		if (last) expr_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_var(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx <= CFG_VAR_E) var_val[idx] = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_reset_values();
		send_string("a+b*c");
		wait_drained();
	endtask

	task automatic test_directed();
		write_var(CFG_VAR_A, 32'h7FFF_FFFF);
		write_var(CFG_VAR_B, 32'h8000_0000);
		write_var(CFG_VAR_C, 32'h0001_0000);
		write_var(CFG_VAR_D, 32'h0000_0000);
		write_var(CFG_VAR_E, 32'hFFFE_8000);
		write_var(3'd5, 32'h1234_5678);
		write_var(3'd7, 32'hFFFF_FFFF);
		send_string("a+a");
		send_string("b-a");
		send_string("a*a");
		send_string("b*e");
		send_string("a/c");
		send_string("c/d");
		send_string("e-c-c");
		send_string("(a+b)*e");
		send_string("c)");
		send_string("(c");
		send_string("c d");
		send_string("c+");
		send_string("+");
		send_string("cccccccccccccccccc");
		send_string("((((((((((((((((((c");
		send_string("c/d+a)");
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);
		send_string("e/e*c");
		wait_drained();
	endtask

	function automatic logic [7:0] random_letter();
		return CH_A + 8'($urandom_range(0, 4));
	endfunction

	function automatic logic [7:0] random_op();
		case ($urandom_range(0, 3))
			0: return CH_ADD;
			1: return CH_SUB;
			2: return CH_MUL;
			default: return CH_DIV;
		endcase
	endfunction

	// builds a well-formed expression, depth kept within the stacks
	function automatic string build_expr(input int level);
		string s;
		int terms;
		terms = $urandom_range(1, 4);
		s = "";
		for (int i = 0; i < terms; i++) begin
			if (i > 0) s = {s, string'(random_op())};
			if (level < 3 && $urandom_range(0, 3) == 0)
				s = {s, "(", build_expr(level + 1), ")"};
			else s = {s, string'(random_letter())};
			if ($urandom_range(0, 9) == 0) s = {s, " "};
		end
		return s;
	endfunction

	task automatic randomize_vars();
		for (int i = 0; i <= 4; i++) begin
			case ($urandom_range(0, 5))
				0: write_var(3'(i), 32'd0);
				1: write_var(3'(i), $urandom_range(0, 8) << 16);
				2: write_var(3'(i), -($urandom_range(1, 8) << 16));
				3: write_var(3'(i), 32'h7FFF_FFFF);
				4: write_var(3'(i), 32'h8000_0000);
				default: write_var(3'(i), $urandom);
			endcase
		end
	endtask

	task automatic test_random(input int n_chars);
		string s;
		int start;
		start = chars_sent;
		while (chars_sent - start < n_chars) begin
			if ($urandom_range(0, 9) < 8) begin
				s = build_expr(0);
				if ($urandom_range(0, 9) == 0) s[$urandom_range(0, s.len() - 1)] = ")";
				send_string(s);
			end else begin
				repeat ($urandom_range(0, 5)) send_char(8'($urandom), 1'b0);
				send_char(8'($urandom), 1'b1);
			end
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_cycles = 3000;
		long_hold = 1;
		for (int i = 0; i < 8; i++) send_string(build_expr(0));
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = '0;
		end_of_expr = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		long_hold = 0;
		hold_cycles = 0;
		mismatches = 0;
		results_seen = 0;
		chars_sent = 0;
		expr_sent = 0;
		burst_left = 0;
		vcnt = 0;
		ocnt = 0;
		err = ST_OK;
		for (int i = 0; i < 5; i++) var_val[i] = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_directed();
		for (int ph = 0; ph < 6; ph++) begin
			randomize_vars();
			test_random(300);
		end
		test_backpressure();

		$display("covered %0d characters in %0d expressions, %0d results checked",
			chars_sent, expr_sent, results_seen);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
